// ===== hdl/isoep_pkg.sv =====
package isoep_pkg;

    localparam int unsigned TEXT_W   = 8;
    localparam int unsigned SECS_W   = 39;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned FIELD_W  = 7;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned YM4800_W = 15;

    localparam logic [POS_W-1:0] POS_LAST = 5'd19;
    localparam logic [POS_W-1:0] POS_LEN  = 5'd20;
    localparam logic [POS_W-1:0] POS_SAT  = 5'd21;

    localparam logic [TEXT_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [TEXT_W-1:0] CH_T     = 8'h54;
    localparam logic [TEXT_W-1:0] CH_COLON = 8'h3A;
    localparam logic [TEXT_W-1:0] CH_Z     = 8'h5A;
    localparam logic [TEXT_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [TEXT_W-1:0] CH_NINE  = 8'h39;

    localparam logic [YEAR_W-1:0] YEAR_REFUSED   = 14'd1582;
    localparam logic [YEAR_W-1:0] YEAR_GREGORIAN = 14'd1583;
    localparam logic [YM4800_W-1:0] YEAR_SHIFT   = 15'd4800;

    localparam int unsigned JDN_UNIX   = 2440588;
    localparam int unsigned GREG_BIAS  = 32045 + JDN_UNIX;
    localparam int unsigned JUL_BIAS   = 32083 + JDN_UNIX;
    localparam int unsigned DAYS_W     = 25;
    localparam int unsigned SECS_PER_DAY = 86400;

    // floor(y/100) = (y * 5243) >> 19, exact for y below 43690
    localparam int unsigned DIV100_MUL   = 5243;
    localparam int unsigned DIV100_SHIFT = 19;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               shape_ok;
        logic [FIELD_W-1:0] year_hi;
        logic [FIELD_W-1:0] year_lo;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
    } stamp_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_CHECK,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_DONE
    } back_state_t;

    // day offset of a March-based month index, (153*m + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] month_days(input logic [FIELD_W-1:0] month,
                                                      input logic leap);
        logic [FIELD_W-1:0] r;
        unique case (month)
            7'd2:                      r = leap ? 7'd29 : 7'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   r = 7'd30;
            default:                   r = 7'd31;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/isoep_text_if.sv =====
interface isoep_text_if
    import isoep_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TEXT_W-1:0] text_byte;
    logic              final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// ===== hdl/isoep_result_if.sv =====
interface isoep_result_if
    import isoep_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic signed [SECS_W-1:0] epoch_seconds;

    modport source (output valid, output accepted, output epoch_seconds, input ready);
    modport sink   (input valid, input accepted, input epoch_seconds, output ready);
endinterface

// ===== hdl/isoep_front.sv =====
module isoep_front
    import isoep_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    isoep_text_if.sink          text,
    input  logic                queue_full,
    output logic                push,
    output stamp_rec_t          push_rec
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               err_reg, err_next;
    logic [FIELD_W-1:0] yhi_reg, ylo_reg, mon_reg, day_reg, hr_reg, min_reg, sec_reg;
    logic [FIELD_W-1:0] yhi_next, ylo_next, mon_next, day_next, hr_next, min_next, sec_next;

    logic               accept;
    logic               is_digit;
    logic [FIELD_W-1:0] digit;
    logic               sep_place;
    logic [TEXT_W-1:0]  sep_char;

    function automatic logic [FIELD_W-1:0] shift_in(input logic [FIELD_W-1:0] f,
                                                    input logic [FIELD_W-1:0] d);
        return f * 7'd10 + d;
    endfunction

    assign text.ready = !queue_full;
    assign accept     = text.valid && text.ready;
    assign is_digit   = (text.text_byte >= CH_ZERO) && (text.text_byte <= CH_NINE);
    assign digit      = FIELD_W'(text.text_byte - CH_ZERO);

    always_comb
    begin
        sep_place = 1'b1;
        sep_char  = CH_DASH;
        unique case (pos_reg)
            5'd4, 5'd7:   sep_char = CH_DASH;
            5'd10:        sep_char = CH_T;
            5'd13, 5'd16: sep_char = CH_COLON;
            5'd19:        sep_char = CH_Z;
            default:      sep_place = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        err_next = err_reg;
        yhi_next = yhi_reg;
        ylo_next = ylo_reg;
        mon_next = mon_reg;
        day_next = day_reg;
        hr_next  = hr_reg;
        min_next = min_reg;
        sec_next = sec_reg;
        push     = 1'b0;
        push_rec = '0;

        if (accept)
        begin
            if (pos_reg >= POS_LEN)
                err_next = 1'b1;
            else if (sep_place)
            begin
                if (text.text_byte != sep_char)
                    err_next = 1'b1;
            end
            else if (!is_digit)
                err_next = 1'b1;
            else
            begin
                unique case (pos_reg)
                    5'd0, 5'd1:   yhi_next = shift_in(yhi_reg, digit);
                    5'd2, 5'd3:   ylo_next = shift_in(ylo_reg, digit);
                    5'd5, 5'd6:   mon_next = shift_in(mon_reg, digit);
                    5'd8, 5'd9:   day_next = shift_in(day_reg, digit);
                    5'd11, 5'd12: hr_next  = shift_in(hr_reg, digit);
                    5'd14, 5'd15: min_next = shift_in(min_reg, digit);
                    default:      sec_next = shift_in(sec_reg, digit);
                endcase
            end

            if (pos_reg < POS_SAT)
                pos_next = pos_reg + 5'd1;

            if (text.final_byte)
            begin
                push              = 1'b1;
                push_rec.shape_ok = !err_next && (pos_reg == POS_LAST);
                push_rec.year_hi  = yhi_reg;
                push_rec.year_lo  = ylo_reg;
                push_rec.month    = mon_reg;
                push_rec.day      = day_reg;
                push_rec.hour     = hr_reg;
                push_rec.minute   = min_reg;
                push_rec.second   = sec_reg;
                pos_next = '0;
                err_next = 1'b0;
                yhi_next = '0;
                ylo_next = '0;
                mon_next = '0;
                day_next = '0;
                hr_next  = '0;
                min_next = '0;
                sec_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            err_reg <= 1'b0;
            yhi_reg <= '0;
            ylo_reg <= '0;
            mon_reg <= '0;
            day_reg <= '0;
            hr_reg  <= '0;
            min_reg <= '0;
            sec_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            err_reg <= err_next;
            yhi_reg <= yhi_next;
            ylo_reg <= ylo_next;
            mon_reg <= mon_next;
            day_reg <= day_next;
            hr_reg  <= hr_next;
            min_reg <= min_next;
            sec_reg <= sec_next;
        end
    end

endmodule

// ===== hdl/isoep_queue.sv =====
module isoep_queue
    import isoep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  stamp_rec_t push_rec,
    output logic       full,
    input  logic       pop,
    output stamp_rec_t pop_rec,
    output logic       empty
);

    stamp_rec_t          mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hdl/isoep_back.sv =====
module isoep_back
    import isoep_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           queue_empty,
    input  stamp_rec_t     queue_rec,
    output logic           pop,
    isoep_result_if.source result
);

    back_state_t state_reg, state_next;

    stamp_rec_t                 rec_reg;
    logic [YEAR_W-1:0]          year_reg;
    logic [YM4800_W-1:0]        y_reg;
    logic                       ok_reg;
    logic                       greg_reg;
    logic [8:0]                 moff_reg;
    logic [18:0]                hr_secs_reg;
    logic [12:0]                min_secs_reg;
    logic [18:0]                tod_reg;
    logic [22:0]                y365_reg;
    logic [7:0]                 q100_reg;
    logic signed [DAYS_W-1:0]   days_reg;
    logic signed [SECS_W-1:0]   prod_reg;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_acc_reg;
    logic signed [SECS_W-1:0]   out_secs_reg;
    logic                       out_load;

    logic                       early;
    logic [3:0]                 m_idx;
    logic                       greg_c;
    logic                       leap_c;
    logic                       ok_c;
    logic [29:0]                y_scaled;
    logic [22:0]                pos_sum;
    logic [22:0]                neg_sum;

    assign result.valid         = out_valid_reg;
    assign result.accepted      = out_acc_reg;
    assign result.epoch_seconds = out_secs_reg;

    // January and February count as months 10 and 11 of the previous year
    assign early  = (rec_reg.month <= 7'd2);
    assign m_idx  = early ? (rec_reg.month[3:0] + 4'd9) : (rec_reg.month[3:0] - 4'd3);
    assign greg_c = (year_reg >= YEAR_GREGORIAN);

    // leap year from the two digit pairs: year mod 4, 100, 400 for Gregorian years, mod 4 alone for Julian
    always_comb
    begin
        if (greg_c)
            leap_c = ((rec_reg.year_lo[1:0] == 2'b00) && (rec_reg.year_lo != '0)) ||
                     ((rec_reg.year_lo == '0) && (rec_reg.year_hi[1:0] == 2'b00));
        else
            leap_c = (rec_reg.year_lo[1:0] == 2'b00);
    end

    assign ok_c = rec_reg.shape_ok &&
                  (rec_reg.month >= 7'd1) && (rec_reg.month <= 7'd12) &&
                  (rec_reg.day >= 7'd1) &&
                  (rec_reg.day <= month_days(rec_reg.month, leap_c)) &&
                  (rec_reg.hour <= 7'd23) && (rec_reg.minute <= 7'd59) &&
                  (rec_reg.second <= 7'd59) &&
                  (year_reg != '0) && (year_reg != YEAR_REFUSED);

    assign y_scaled = {15'b0, y_reg} * 30'(DIV100_MUL);

    assign pos_sum = {16'b0, rec_reg.day} + {14'b0, moff_reg} + y365_reg +
                     {10'b0, y_reg[YM4800_W-1:2]};
    assign neg_sum = greg_reg ?
                     (23'(GREG_BIAS) + {15'b0, q100_reg} - {17'b0, q100_reg[7:2]}) :
                     23'(JUL_BIAS);

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        if (result.ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:  state_next = ST_CHECK;
            ST_CHECK: state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rec_reg <= queue_rec;
        if (state_reg == ST_YEAR)
        begin
            year_reg     <= {7'b0, rec_reg.year_hi} * 14'd100 + {7'b0, rec_reg.year_lo};
            hr_secs_reg  <= {12'b0, rec_reg.hour} * 19'd3600;
            min_secs_reg <= {6'b0, rec_reg.minute} * 13'd60;
        end
        if (state_reg == ST_CHECK)
        begin
            y_reg    <= {1'b0, year_reg} + YEAR_SHIFT - {14'b0, early};
            moff_reg <= month_offset(m_idx);
            ok_reg   <= ok_c;
            greg_reg <= greg_c;
            tod_reg  <= hr_secs_reg + {6'b0, min_secs_reg} + {12'b0, rec_reg.second};
        end
        if (state_reg == ST_MUL)
        begin
            y365_reg <= {8'b0, y_reg} * 23'd365;
            q100_reg <= y_scaled[DIV100_SHIFT+7:DIV100_SHIFT];
        end
        if (state_reg == ST_SUM)
            days_reg <= $signed({2'b0, pos_sum}) - $signed({2'b0, neg_sum});
        if (state_reg == ST_SCALE)
            prod_reg <= $signed(SECS_W'(days_reg)) * $signed(SECS_W'(SECS_PER_DAY));
        if (out_load)
        begin
            out_acc_reg  <= ok_reg;
            out_secs_reg <= ok_reg ? (prod_reg + $signed({20'b0, tod_reg})) : '0;
        end
    end

endmodule

// ===== hdl/iso8601_utc_to_epoch_seconds_unit.sv =====
// Parses "YYYY-MM-DDTHH:MM:SSZ" strings, one byte per beat on text with final_byte
// on the last, and returns one result beat per string: accepted with signed seconds since
// 1970-01-01T00:00:00Z, or accepted low with zero seconds for any bad shape, length, field
// range or refused year (0 and 1582; earlier years are taken as Julian dates). The byte
// parser takes one beat per cycle while the queue is not full. The calendar conversion
// runs in a separate sequencer behind a 2-entry queue of parsed strings; it takes a new
// string only after the last result is loaded for output, which waits on result.ready,
// and text stalls on every byte while the queue is full.
module iso8601_utc_to_epoch_seconds_unit
    import isoep_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    isoep_text_if.sink     text,
    isoep_result_if.source result
);

    logic       push;
    stamp_rec_t push_rec;
    logic       queue_full;
    logic       pop;
    stamp_rec_t pop_rec;
    logic       queue_empty;

    isoep_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .queue_full (queue_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    isoep_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (queue_full),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .empty    (queue_empty)
    );

    isoep_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_rec   (pop_rec),
        .pop         (pop),
        .result      (result)
    );

endmodule
